/* design/ohlc_pkg.sv */
// shared types and constants for the ohlc minute bar aggregator
package ohlc_pkg;

   // field widths
   localparam int PRICE_W  = 32;
   localparam int TIME_W   = 64;
   localparam int SLOT_W   = 14;
   localparam int OFFS_W   = 14;
   localparam int WDAY_W   = 3;

   localparam int SLOT_COUNT_DEFAULT = 16384;

   // one minute is 2^11 * 29296875 ns: the timestamp is shifted by 11, then the
   // 53-bit rest is divided by the odd factor through a 54-bit reciprocal (shift 78)
   localparam int MIN_SHIFT = 11;
   localparam int MINX_W    = TIME_W - MIN_SHIFT;
   localparam int ACC_W     = 56;
   localparam int MIN_Q_LSB = 14;
   localparam int MIN_W     = 29;
   localparam logic [53:0] MIN_RECIP = 54'(((79'd1 << 78) / 79'd29296875) + 79'd1);

   // minutes modulo one week through a 30-bit reciprocal (shift 43)
   localparam int WQ_W = 15;
   localparam logic [29:0] WEEK_RECIP = 30'd872628277;

   localparam logic [SLOT_W-1:0] MINUTES_PER_DAY  = 14'd1440;
   localparam logic [SLOT_W-1:0] MINUTES_PER_WEEK = 14'd10080;

   // register reset values
   localparam logic [OFFS_W-1:0] WEEK_START_RESET = 14'd1320;
   localparam logic [WDAY_W-1:0] WEEKDAY_RESET    = 3'd4;

   // register indexes, taken from paddr[2]
   localparam logic REG_WEEK_START = 1'b0;
   localparam logic REG_WEEKDAY    = 1'b1;

   typedef struct packed {
      logic [PRICE_W-1:0] open_p;
      logic [PRICE_W-1:0] high_p;
      logic [PRICE_W-1:0] low_p;
      logic [PRICE_W-1:0] close_p;
      logic [PRICE_W-1:0] count;
   } candle_type;

   // controller to datapath
   typedef struct packed {
      logic cap;
      logic mul;
      logic mul_hi_x;
      logic mul_hi_m;
      logic wk_quot;
      logic wk_rem;
      logic mow_eval;
      logic slot_eval;
      logic clr_we;
      logic rd_en;
      logic upd;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic cleared;
      logic clr_last;
      logic out_free;
   } ctrl_stat_type;

endpackage

/* design/ohlc_ifs.sv */
// tick and candle channel interfaces
interface ohlc_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] bid_price;
   logic [63:0] tick_time;
   modport source (output valid, output bid_price, output tick_time, input ready);
   modport sink (input valid, input bid_price, input tick_time, output ready);
endinterface

interface ohlc_rsp_if;
   logic        valid;
   logic        ready;
   logic [13:0] slot_index;
   logic [31:0] open_price;
   logic [31:0] high_price;
   logic [31:0] low_price;
   logic [31:0] close_price;
   logic [31:0] tick_count;
   logic        store_cleared;
   logic        analysis_due;
   modport source (output valid, output slot_index, output open_price, output high_price,
                   output low_price, output close_price, output tick_count,
                   output store_cleared, output analysis_due, input ready);
   modport sink (input valid, input slot_index, input open_price, input high_price,
                 input low_price, input close_price, input tick_count,
                 input store_cleared, input analysis_due, output ready);
endinterface

/* design/ohlc_minute_bar_aggregator_top.sv */
// Minute bar aggregator: each tick is mapped to a minute slot of the trading week and folded
// into that slot's open/high/low/close/count candle; one candle beat comes out per tick.
// A taken tick is worked through in order: four steps multiply the shifted timestamp by the
// reciprocal of one minute (one 32x32 partial product each), two reduce the minute count modulo
// one week, one adds the weekday shift, then one step each for the slot, the store read and the
// read-modify-write, whose result is registered as the candle beat. A new tick is not taken
// until that update is done, and a candle beat still waiting holds the following tick in its
// update cycle. After reset, and whenever a tick lands in an earlier slot than the previous
// one, a clearing pass walks the store one entry a cycle (all SLOT_COUNT entries, 16384 by
// default) and no tick is taken during the reset pass.
// Registers: 0x0 week start offset (14 bits), 0x4 epoch weekday offset (3 bits).
module ohlc_minute_bar_aggregator_top #(
   parameter int SLOT_COUNT = ohlc_pkg::SLOT_COUNT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   ohlc_req_if.sink    req,
   ohlc_rsp_if.source  rsp,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import ohlc_pkg::*;

   logic [OFFS_W-1:0] week_start_ff;
   logic [WDAY_W-1:0] weekday_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         week_start_ff <= WEEK_START_RESET;
         weekday_ff    <= WEEKDAY_RESET;
      end else if (psel && penable && pwrite) begin
         unique case (paddr[2])
            REG_WEEK_START: week_start_ff <= pwdata[OFFS_W-1:0];
            REG_WEEKDAY:    weekday_ff    <= pwdata[WDAY_W-1:0];
            default: ;
         endcase
      end
   end

   assign pready = 1'b1;
   always_comb begin
      unique case (paddr[2])
         REG_WEEK_START: prdata = {18'b0, week_start_ff};
         REG_WEEKDAY:    prdata = {29'b0, weekday_ff};
         default:        prdata = '0;
      endcase
   end

   ctrl_cmd_type  cmd;
   ctrl_stat_type stat;
   logic          in_ready;

   assign req.ready = in_ready;

   ohlc_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req.valid),
      .in_ready (in_ready),
      .stat     (stat),
      .cmd      (cmd)
   );

   ohlc_dpath #(.SLOT_COUNT(SLOT_COUNT)) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .bid_price   (req.bid_price),
      .tick_time   (req.tick_time),
      .week_start  (week_start_ff),
      .weekday_off (weekday_ff),
      .cmd         (cmd),
      .stat        (stat),
      .rsp         (rsp)
   );

endmodule

/* design/ohlc_ctrl.sv */
// sequencer for the slot arithmetic, store clearing and candle update
module ohlc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  ohlc_pkg::ctrl_stat_type stat,
   output ohlc_pkg::ctrl_cmd_type  cmd
);
   import ohlc_pkg::*;

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_MUL   = 9'b000000010,
      ST_WKQ   = 9'b000000100,
      ST_WKR   = 9'b000001000,
      ST_MOW   = 9'b000010000,
      ST_SLOT  = 9'b000100000,
      ST_CLEAR = 9'b001000000,
      ST_READ  = 9'b010000000,
      ST_UPD   = 9'b100000000
   } state_type;

   state_type  state_ff, state_in;
   logic       item_ff, item_in;
   logic [1:0] cnt_ff, cnt_in;

   // state registers; the store is swept clean right after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         item_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         item_ff  <= item_in;
         cnt_ff   <= cnt_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      item_in  = item_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      in_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.cap  = 1'b1;
               item_in  = 1'b1;
               cnt_in   = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            // one partial product per cycle, low limbs first
            cmd.mul = 1'b1;
            {cmd.mul_hi_x, cmd.mul_hi_m} = cnt_ff;
            cnt_in = cnt_ff + 2'd1;
            if (cnt_ff == 2'd3) begin
               state_in = ST_WKQ;
            end
         end
         ST_WKQ: begin
            cmd.wk_quot = 1'b1;
            state_in = ST_WKR;
         end
         ST_WKR: begin
            cmd.wk_rem = 1'b1;
            state_in = ST_MOW;
         end
         ST_MOW: begin
            cmd.mow_eval = 1'b1;
            state_in = ST_SLOT;
         end
         ST_SLOT: begin
            cmd.slot_eval = 1'b1;
            state_in = stat.cleared ? ST_CLEAR : ST_READ;
         end
         ST_CLEAR: begin
            cmd.clr_we = 1'b1;
            if (stat.clr_last) begin
               state_in = item_ff ? ST_READ : ST_IDLE;
            end
         end
         ST_READ: begin
            cmd.rd_en = 1'b1;
            state_in = ST_UPD;
         end
         ST_UPD: begin
            if (stat.out_free) begin
               cmd.upd  = 1'b1;
               item_in  = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* design/ohlc_dpath.sv */
// slot arithmetic, candle store and result register
module ohlc_dpath #(
   parameter int SLOT_COUNT = ohlc_pkg::SLOT_COUNT_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [ohlc_pkg::PRICE_W-1:0] bid_price,
   input  logic [ohlc_pkg::TIME_W-1:0]  tick_time,
   input  logic [ohlc_pkg::OFFS_W-1:0]  week_start,
   input  logic [ohlc_pkg::WDAY_W-1:0]  weekday_off,
   input  ohlc_pkg::ctrl_cmd_type        cmd,
   output ohlc_pkg::ctrl_stat_type       stat,
   ohlc_rsp_if.source                    rsp
);
   import ohlc_pkg::*;

   localparam int AW = $clog2(SLOT_COUNT);

   logic [PRICE_W-1:0] bid_ff;
   logic [MINX_W-1:0]  x_ff;
   logic [ACC_W-1:0]   acc_ff;
   logic [WQ_W-1:0]    wq_ff;
   logic [SLOT_W-1:0]  w_ff, mow_ff;
   logic [AW-1:0]      slot_ff, cur_ff, clr_cnt_ff;
   logic               clr_flag_ff, due_ff;

   // minute count: shifted timestamp times reciprocal, one 32x32 product a cycle
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   always_comb begin
      mul_a = cmd.mul_hi_x ? 32'(x_ff[MINX_W-1:32]) : x_ff[31:0];
      mul_b = cmd.mul_hi_m ? 32'(MIN_RECIP[53:32]) : MIN_RECIP[31:0];
      mul_p = {32'b0, mul_a} * {32'b0, mul_b};
   end

   always_ff @(posedge clock) begin
      if (cmd.cap) begin
         bid_ff <= bid_price;
         x_ff   <= tick_time[TIME_W-1:MIN_SHIFT];
      end
      if (cmd.mul) begin
         if (!cmd.mul_hi_x && !cmd.mul_hi_m) begin
            acc_ff <= ACC_W'(mul_p[63:32]);
         end else if (cmd.mul_hi_x && cmd.mul_hi_m) begin
            acc_ff <= ACC_W'(acc_ff[ACC_W-1:32]) + ACC_W'(mul_p);
         end else begin
            acc_ff <= acc_ff + ACC_W'(mul_p);
         end
      end
   end

   // minutes modulo one week
   logic [MIN_W-1:0]  minutes;
   logic [58:0]       wq_p;
   logic [28:0]       wq_full;
   always_comb begin
      minutes = acc_ff[MIN_Q_LSB+MIN_W-1:MIN_Q_LSB];
      wq_p    = {30'b0, minutes} * {29'b0, WEEK_RECIP};
      wq_full = {14'b0, wq_ff} * {15'b0, MINUTES_PER_WEEK};
   end

   // weekday shift folded back into the week
   logic [SLOT_W-1:0] day_shift;
   logic [SLOT_W:0]   mow_sum;
   logic [SLOT_W-1:0] mow_in;
   always_comb begin
      day_shift = 14'({11'b0, weekday_off} * MINUTES_PER_DAY);
      mow_sum   = {1'b0, w_ff} + {1'b0, day_shift};
      mow_in    = (mow_sum >= {1'b0, MINUTES_PER_WEEK}) ?
                  14'(mow_sum - {1'b0, MINUTES_PER_WEEK}) : mow_sum[SLOT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.wk_quot) begin
         wq_ff <= wq_p[43+WQ_W-1:43];
      end
      if (cmd.wk_rem) begin
         w_ff <= minutes[SLOT_W-1:0] - wq_full[SLOT_W-1:0];
      end
      if (cmd.mow_eval) begin
         mow_ff <= mow_in;
      end
   end

   // offset and clamp
   logic [SLOT_W-1:0] raw;
   logic [AW-1:0]     slot_c;
   always_comb begin
      raw = (mow_ff < week_start) ? '0 : 14'(mow_ff - week_start);
      if ({1'b0, raw} >= 15'(SLOT_COUNT)) begin
         slot_c = AW'(SLOT_COUNT - 1);
      end else begin
         slot_c = raw[AW-1:0];
      end
   end

   assign stat.cleared = slot_c < cur_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff <= '0;
      end else if (cmd.slot_eval) begin
         cur_ff <= slot_c;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.slot_eval) begin
         slot_ff     <= slot_c;
         clr_flag_ff <= slot_c < cur_ff;
         due_ff      <= (slot_c > cur_ff) && (slot_c > AW'(1));
      end
   end

   // clearing sweep address
   assign stat.clr_last = clr_cnt_ff == AW'(SLOT_COUNT - 1);
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clr_we) begin
         clr_cnt_ff <= stat.clr_last ? '0 : clr_cnt_ff + AW'(1);
      end
   end

   // candle store
   candle_type mem [SLOT_COUNT];
   candle_type rd_ff, upd_c, wr_data;
   logic [AW-1:0] wr_addr;
   logic          wr_en;

   always_comb begin
      upd_c = rd_ff;
      if (rd_ff.count != '0) begin
         if (bid_ff > rd_ff.high_p) upd_c.high_p = bid_ff;
         if (bid_ff < rd_ff.low_p)  upd_c.low_p  = bid_ff;
         upd_c.close_p = bid_ff;
         if (rd_ff.count != '1) upd_c.count = rd_ff.count + 32'd1;
      end else begin
         upd_c.open_p  = bid_ff;
         upd_c.high_p  = bid_ff;
         upd_c.low_p   = bid_ff;
         upd_c.close_p = bid_ff;
         upd_c.count   = 32'd1;
      end
      wr_en   = cmd.clr_we | cmd.upd;
      wr_addr = cmd.clr_we ? clr_cnt_ff : slot_ff;
      wr_data = cmd.clr_we ? '0 : upd_c;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_ff <= mem[slot_ff];
      end
   end

   // result register
   logic       rsp_valid_ff;
   candle_type out_ff;
   logic [AW-1:0] out_slot_ff;
   logic       out_clr_ff, out_due_ff;

   assign stat.out_free = !rsp_valid_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.upd) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.upd) begin
         out_ff      <= upd_c;
         out_slot_ff <= slot_ff;
         out_clr_ff  <= clr_flag_ff;
         out_due_ff  <= due_ff;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.slot_index    = SLOT_W'(out_slot_ff);
   assign rsp.open_price    = out_ff.open_p;
   assign rsp.high_price    = out_ff.high_p;
   assign rsp.low_price     = out_ff.low_p;
   assign rsp.close_price   = out_ff.close_p;
   assign rsp.tick_count    = out_ff.count;
   assign rsp.store_cleared = out_clr_ff;
   assign rsp.analysis_due  = out_due_ff;

endmodule

/* bench/ohlc_candle_checker.sv */
// candle predictor and result comparator for the minute bar aggregator bench
module ohlc_candle_checker (
   input  logic        clock,
   input  logic        reset,
   ohlc_req_if         req,
   ohlc_rsp_if         rsp,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic        pready,
   output int          error_count,
   output int          pending
);
   import ohlc_pkg::*;

   localparam int SLOTS = SLOT_COUNT_DEFAULT;
   localparam longint unsigned NS_DAY = 64'd86400000000000;
   localparam longint unsigned NS_MIN = 64'd60000000000;

   typedef struct {
      logic [SLOT_W-1:0] slot;
      candle_type        bar;
      logic              cleared;
      logic              due;
   } candle_beat_type;

   candle_type        candles [SLOTS];
   logic [SLOT_W-1:0] cur_slot;
   logic [OFFS_W-1:0] week_start;
   logic [WDAY_W-1:0] weekday_base;
   candle_beat_type   expected_bars [$];

   initial error_count = 0;
   assign pending = expected_bars.size();

   // minute slot of the trading week for a timestamp
   function automatic logic [SLOT_W-1:0] minute_slot(input logic [63:0] t);
      longint unsigned day, wday, mod, mow;
      day  = t / NS_DAY;
      wday = ((day % 7) + longint'(weekday_base)) % 7;
      mod  = (t % NS_DAY) / NS_MIN;
      mow  = wday * 1440 + mod;
      if (mow < longint'(week_start)) return '0;
      mow = mow - longint'(week_start);
      if (mow >= SLOTS) mow = SLOTS - 1;
      return mow[SLOT_W-1:0];
   endfunction

   // fold one tick into the candle store and queue the expected beat
   function automatic void fold_tick(input logic [31:0] bid, input logic [63:0] t);
      candle_beat_type   beat;
      logic [SLOT_W-1:0] s;
      s = minute_slot(t);
      beat.slot    = s;
      beat.cleared = s < cur_slot;
      beat.due     = (s > cur_slot) && (s > 1);
      if (beat.cleared)
         foreach (candles[i]) candles[i] = '0;
      cur_slot = s;
      if (candles[s].count != 0) begin
         if (bid > candles[s].high_p) candles[s].high_p = bid;
         if (bid < candles[s].low_p) candles[s].low_p = bid;
         candles[s].close_p = bid;
         if (candles[s].count != 32'hFFFF_FFFF) candles[s].count++;
      end else begin
         candles[s] = '{bid, bid, bid, bid, 32'd1};
      end
      beat.bar = candles[s];
      expected_bars.push_back(beat);
   endfunction

   always @(posedge clock) begin
      candle_beat_type want;
      if (reset) begin
         foreach (candles[i]) candles[i] = '0;
         cur_slot     = '0;
         week_start   = WEEK_START_RESET;
         weekday_base = WEEKDAY_RESET;
         expected_bars.delete();
      end else begin
         // register writes
         if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_WEEKDAY) weekday_base = pwdata[WDAY_W-1:0];
            else week_start = pwdata[OFFS_W-1:0];
         end
         // tick beat
         if (req.valid && req.ready) fold_tick(req.bid_price, req.tick_time);
         // candle beat
         if (rsp.valid && rsp.ready) begin
            if (expected_bars.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("unexpected candle beat slot %0d", rsp.slot_index);
            end else begin
               want = expected_bars.pop_front();
               if (rsp.slot_index !== want.slot || rsp.open_price !== want.bar.open_p ||
                   rsp.high_price !== want.bar.high_p || rsp.low_price !== want.bar.low_p ||
                   rsp.close_price !== want.bar.close_p || rsp.tick_count !== want.bar.count ||
                   rsp.store_cleared !== want.cleared || rsp.analysis_due !== want.due) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("mismatch exp slot %0d o %h h %h l %h c %h n %h clr %b due %b",
                              want.slot, want.bar.open_p, want.bar.high_p, want.bar.low_p,
                              want.bar.close_p, want.bar.count, want.cleared, want.due,
                              "\n         got slot %0d o %h h %h l %h c %h n %h clr %b due %b",
                              rsp.slot_index, rsp.open_price, rsp.high_price, rsp.low_price,
                              rsp.close_price, rsp.tick_count, rsp.store_cleared,
                              rsp.analysis_due);
               end
            end
         end
      end
   end

endmodule

/* bench/tb_ohlc_minute_bar_aggregator_top.sv */
// stimulus, clocking and verdict for the minute bar aggregator bench
module tb_ohlc_minute_bar_aggregator_top;
   import ohlc_pkg::*;

   localparam longint unsigned NS_DAY = 64'd86400000000000;
   localparam longint unsigned NS_MIN = 64'd60000000000;
   localparam longint unsigned NS_SEC = 64'd1000000000;
   localparam int CYCLE_LIMIT = 4000000;
   localparam int DRAIN_WAIT  = 16500;

   logic        clock = 1'b0;
   logic        reset;
   logic        psel, penable, pwrite, pready;
   logic [2:0]  paddr;
   logic [31:0] pwdata, prdata;
   int          error_count, pending;
   int          ticks_sent = 0;
   int          cycles = 0;
   logic        hold_off = 1'b0;
   logic        quiet = 1'b0;
   int          stall_left = 0;

   ohlc_req_if req ();
   ohlc_rsp_if rsp ();

   ohlc_minute_bar_aggregator_top dut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   ohlc_candle_checker checker_i (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .pready(pready), .error_count(error_count), .pending(pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // candle receiver with random stalls
   always @(posedge clock) begin
      if (hold_off) begin
         rsp.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp.ready  <= 1'b0;
      end else begin
         rsp.ready <= 1'b1;
         if (!quiet) begin
            if ($urandom_range(0, 39) == 0) stall_left <= $urandom_range(20, 150);
            else if ($urandom_range(0, 3) == 0) stall_left <= $urandom_range(1, 3);
         end
      end
   end

   // long receiver hold-off while ticks keep coming
   initial begin
      wait (ticks_sent == 150);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (3000) @(posedge clock);
      hold_off <= 1'b0;
   end

   task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // offer one tick beat, returning at the edge where it is taken
   task automatic send_tick(input logic [31:0] bid, input logic [63:0] t);
      int   gap;
      logic took;
      gap = 0;
      if (!quiet) begin
         if ($urandom_range(0, 49) == 0) gap = $urandom_range(20, 200);
         else if ($urandom_range(0, 1) == 0) gap = $urandom_range(1, 3);
      end
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid     <= 1'b1;
      req.bid_price <= bid;
      req.tick_time <= t;
      do begin
         @(negedge clock);
         took = req.ready;
         @(posedge clock);
      end while (!took);
      ticks_sent++;
      if (ticks_sent % 97 == 0) quiet = ~quiet;
   endtask

   task automatic drain_idle();
      @(posedge clock);
      req.valid <= 1'b0;
      wait (pending == 0);
      @(posedge clock);
   endtask

   function automatic logic [31:0] pick_bid();
      case ($urandom_range(0, 9))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      logic [13:0]     offs [5];
      logic [2:0]      wday [5];
      longint unsigned cursor, base, step;
      int              r;

      req.valid     = 1'b0;
      req.bid_price = '0;
      req.tick_time = '0;
      rsp.ready     = 1'b0;
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      paddr   = '0;
      pwdata  = '0;
      reset   = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      offs = '{WEEK_START_RESET, 14'd0, 14'd10079, 14'($urandom_range(0, 10079)),
               14'($urandom_range(0, 10079))};
      wday = '{WEEKDAY_RESET, 3'd0, 3'd6, 3'd7, 3'($urandom_range(0, 6))};

      for (int ph = 0; ph < 5; ph++) begin
         // registers change only with the block idle
         reg_write({REG_WEEK_START, 2'b00}, 32'(offs[ph]));
         reg_write({REG_WEEKDAY, 2'b00}, 32'(wday[ph]));

         if (ph == 0) begin
            // field extremes, backwards jump, repeated slot, clamp and early slots
            send_tick(32'd0, 64'd0);
            send_tick(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
            send_tick(32'd7, 64'd0);
            base = 64'd10 * NS_DAY + 64'd3 * 60 * NS_MIN;
            send_tick(32'd100, base);
            send_tick(32'd50, base + 5 * NS_SEC);
            send_tick(32'd200, base + 10 * NS_SEC);
            send_tick(32'd75, base + 59 * NS_SEC);
            send_tick(32'd80, base + NS_MIN);
            send_tick(32'hFFFF_FFFF, base + NS_MIN + NS_SEC);
            send_tick(32'd0, base + NS_MIN + 2 * NS_SEC);
            base = 64'd3 * NS_DAY;
            send_tick(32'd11, base + 10 * NS_MIN);
            send_tick(32'd12, base + 1321 * NS_MIN);
            send_tick(32'd13, base + 1322 * NS_MIN);
            send_tick(32'd14, base + 1322 * NS_MIN + NS_SEC);
         end

         // random ticks, mostly moving forward in time
         cursor = longint'($urandom_range(0, 150000)) * NS_DAY +
                  longint'($urandom_range(0, 86399)) * NS_SEC;
         for (int k = 0; k < 240; k++) begin
            if (k == 120) drain_idle();
            r = $urandom_range(0, 99);
            if (r < 45) begin
               step = longint'($urandom_range(0, 20000)) * 64'd1000000;
               cursor += step;
               send_tick(pick_bid(), cursor);
            end else if (r < 85) begin
               cursor += longint'($urandom_range(1, 90)) * NS_SEC;
               send_tick(pick_bid(), cursor);
            end else if (r < 97) begin
               cursor += longint'($urandom_range(1, 600)) * NS_MIN;
               send_tick(pick_bid(), cursor);
            end else if (r < 99) begin
               step = longint'($urandom_range(1, 3000)) * NS_MIN;
               if (cursor > step) cursor -= step;
               send_tick(pick_bid(), cursor);
            end else begin
               send_tick($urandom, {$urandom, $urandom});
            end
         end

         drain_idle();
         repeat (DRAIN_WAIT) @(posedge clock);
      end

      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
